>>> src/sle_pkg.sv
// sle_pkg: shared types and codes for the sorted list engine
// request and status codes, the sequencer state and the cell command struct
// no dependencies
`default_nettype none

package sle_pkg;

    localparam int ValueWidth = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_e_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_e_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_e_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_e_t                    op;
        logic signed [ValueWidth-1:0]  value;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> src/sle_req_if.sv
// sle_req_if: request channel of the sorted list engine
// valid/ready handshake with request type and value; no dependencies
`default_nettype none

interface sle_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

>>> src/sle_rsp_if.sv
// sle_rsp_if: result channel of the sorted list engine
// valid/ready handshake with item value, status and last mark; no dependencies
`default_nettype none

interface sle_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output item_value, output status, output last,
                    input ready);
    modport sink   (input valid, input item_value, input status, input last,
                    output ready);
endinterface

`default_nettype wire

>>> src/sle_cell.sv
// sle_cell: one entry of the sorted list chain
// holds a value and takes it from itself, a neighbor or the command; uses sle_pkg
`default_nettype none

module sle_cell (
    input  wire logic                clk,
    input  wire sle_pkg::cell_cmd_t  cmd,
    input  wire logic                valid_here,
    input  wire logic                valid_next,
    input  wire logic                left_take,
    input  wire logic signed [31:0]  left_value,
    input  wire logic signed [31:0]  right_value,
    input  wire logic signed [31:0]  head_value,
    output logic                     take,
    output logic                     match,
    output logic signed [31:0]       value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               ge;

    // at or after the insert point: not a valid entry that sorts before or equal
    assign take  = !(valid_here && (value_reg <= cmd.value));
    assign match = valid_here && (value_reg == cmd.value);
    // the list is sorted, so every cell from the first match onward is >= value
    assign ge    = valid_here && (value_reg >= cmd.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            sle_pkg::CELL_INSERT:
            begin
                if (take)
                begin
                    value_next = left_take ? left_value : cmd.value;
                end
            end
            sle_pkg::CELL_DELETE:
            begin
                if (ge)
                begin
                    value_next = right_value;
                end
            end
            sle_pkg::CELL_ROTATE:
            begin
                // last valid cell wraps around to the head
                if (valid_here)
                begin
                    value_next = valid_next ? right_value : head_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> src/sorted_list_engine.sv
// sorted_list_engine: bounded ascending list of signed 32-bit values
// top level with request sequencer and chain of sle_cell; uses sle_pkg,
// sle_req_if and sle_rsp_if
//
// usage:
//   req carries one request word (req_type, value); rsp carries result words
//   (item_value, status, last). both move on valid && ready.
//   insert and delete update every cell of the chain at once: the request is
//   taken and its single status word appears in the output register on the
//   next cycle. clear gives no word. a dump of N entries rotates the chain
//   once per word and gives N words, one word per cycle while the receiver
//   takes them, last set on the final one; after the dump the chain is back
//   in its original order. a dump of an empty list gives one word with
//   status empty.
//   a new request is taken only while no dump is running and the output
//   register is free or being read in the same cycle; a stalled receiver
//   holds the output word and pauses a dump.
//   reset empties the list; entry values are not cleared.
`default_nettype none

module sorted_list_engine #(
    parameter int CAPACITY = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sle_req_if.sink     req,
    sle_rsp_if.source   rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    sle_pkg::state_e_t   state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  out_value_reg, out_value_next;
    sle_pkg::status_e_t  out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    sle_pkg::cell_cmd_t  cmd;
    logic                out_free;
    logic                accept;
    logic                found;
    logic                full;
    logic                empty;
    sle_pkg::req_e_t     req_code;

    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_take;
    logic [CAPACITY-1:0] cell_match;
    logic signed [31:0]  cell_value [CAPACITY];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == sle_pkg::ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign req_code  = sle_pkg::req_e_t'(req.req_type);
    assign found     = |cell_match;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_valid[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_first
                sle_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .valid_here  (cell_valid[gi]),
                    .valid_next  ((CAPACITY > 1) ? (count_reg > CW'(1)) : 1'b0),
                    .left_take   (1'b0),
                    .left_value  (cmd.value),
                    .right_value (cell_value[(gi + 1) % CAPACITY]),
                    .head_value  (cell_value[0]),
                    .take        (cell_take[gi]),
                    .match       (cell_match[gi]),
                    .value       (cell_value[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_last
                sle_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .valid_here  (cell_valid[gi]),
                    .valid_next  (1'b0),
                    .left_take   (cell_take[gi-1]),
                    .left_value  (cell_value[gi-1]),
                    .right_value (cell_value[0]),
                    .head_value  (cell_value[0]),
                    .take        (cell_take[gi]),
                    .match       (cell_match[gi]),
                    .value       (cell_value[gi])
                );
            end
            else
            begin : g_mid
                sle_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .valid_here  (cell_valid[gi]),
                    .valid_next  (count_reg > CW'(gi + 1)),
                    .left_take   (cell_take[gi-1]),
                    .left_value  (cell_value[gi-1]),
                    .right_value (cell_value[gi+1]),
                    .head_value  (cell_value[0]),
                    .take        (cell_take[gi]),
                    .match       (cell_match[gi]),
                    .value       (cell_value[gi])
                );
            end
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (accept && (req_code == sle_pkg::REQ_DUMP) && !empty)
                begin
                    state_next = sle_pkg::ST_DUMP;
                end
            end
            sle_pkg::ST_DUMP:
            begin
                if (out_free && (remain_reg == CW'(1)))
                begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs, chain command and counters
    always_comb
    begin
        cmd.op          = sle_pkg::CELL_HOLD;
        cmd.value       = req.value;
        count_next      = count_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_value_next = req.value;
                    out_last_next  = 1'b1;
                    case (req_code)
                        sle_pkg::REQ_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_status_next = sle_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.op          = sle_pkg::CELL_INSERT;
                                count_next      = count_reg + CW'(1);
                                out_status_next = sle_pkg::STAT_DONE;
                            end
                        end
                        sle_pkg::REQ_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                out_status_next = sle_pkg::STAT_EMPTY;
                            end
                            else if (!found)
                            begin
                                out_status_next = sle_pkg::STAT_MISSING;
                            end
                            else
                            begin
                                cmd.op          = sle_pkg::CELL_DELETE;
                                count_next      = count_reg - CW'(1);
                                out_status_next = sle_pkg::STAT_DONE;
                            end
                        end
                        sle_pkg::REQ_DUMP:
                        begin
                            if (empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = sle_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                remain_next = count_reg;
                            end
                        end
                        sle_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            sle_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    // head goes out, chain rotates one place
                    cmd.op          = sle_pkg::CELL_ROTATE;
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_value[0];
                    out_status_next = sle_pkg::STAT_DONE;
                    out_last_next   = (remain_reg == CW'(1));
                    remain_next     = remain_reg - CW'(1);
                end
            end
            default:
            begin
                cmd.op = sle_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sle_pkg::ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.item_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.last       = out_last_reg;

    // assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_dump_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sle_pkg::ST_DUMP) |-> (remain_reg != '0))
        else $error("dump running with nothing left");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == sle_pkg::ST_IDLE))
        else $error("request taken during dump");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_code == sle_pkg::REQ_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sle_pkg::ST_DUMP) |=> (count_reg == $past(count_reg)))
        else $error("dump changed the entry count");

endmodule

`default_nettype wire
